FILE: rtl/vdm_pkg.sv
// Shared types and constants for the vehicle drive mode state machine.
`default_nettype none

package vdm_pkg;

    // Reset value of the calibrate-button hold time in milliseconds.
    localparam logic [15:0] HOLD_MS_RESET = 16'd3000;

    // Configuration port geometry.
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register indexes, decoded from the word address bit.
    localparam logic REG_HOLD_MS = 1'b0;

    // Vehicle mode codes.
    localparam logic [2:0] MODE_HV_OFF   = 3'd0;
    localparam logic [2:0] MODE_HV_ON    = 3'd1;
    localparam logic [2:0] MODE_WANT_RTD = 3'd2;
    localparam logic [2:0] MODE_RTD      = 3'd3;
    localparam logic [2:0] MODE_WANT_PED = 3'd4;
    localparam logic [2:0] MODE_WANT_STR = 3'd5;
    localparam logic [2:0] MODE_CAL_STR  = 3'd6;
    localparam logic [2:0] MODE_CAL_PED  = 3'd7;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        hv_over_threshold;
        logic        inverter_reset_btn;
        logic        drivetrain_error;
        logic        calib_pedals_btn;
        logic        calib_steering_btn;
        logic        start_btn;
        logic        brake_pressed;
        logic        drivetrain_ready;
        logic        pedals_timed_out;
        logic        steering_timed_out;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       drive_enable;
        logic       drive_torque;
        logic       reset_inverter_pulse;
        logic       buzzer_pulse;
        logic       reset_pedal_timeout_pulse;
        logic       reset_steer_timeout_pulse;
        logic       recal_pedals_pulse;
        logic       recal_steering_pulse;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/vdm_if.sv
// Valid/ready channel interfaces for input ticks and results.
`default_nettype none

interface vdm_in_if import vdm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vdm_out_if import vdm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/vdm_cfg.sv
// APB-style configuration register block holding the hold time.
`default_nettype none

module vdm_cfg import vdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [15:0]       o_hold_ms
);

    logic [15:0] r_hold_ms;
    logic [15:0] n_hold_ms;
    logic        hit_hold;

    // Only the aligned word at offset zero holds a register.
    assign hit_hold = (paddr[2] == REG_HOLD_MS) && (paddr[1:0] == 2'b00);

    always_comb begin
        n_hold_ms = r_hold_ms;
        if (psel && penable && pwrite && hit_hold) begin
            n_hold_ms = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms <= HOLD_MS_RESET;
        end else begin
            r_hold_ms <= n_hold_ms;
        end
    end

    assign prdata    = hit_hold ? {16'b0, r_hold_ms} : '0;
    assign pready    = 1'b1;
    assign o_hold_ms = r_hold_ms;

endmodule

`default_nettype wire

FILE: rtl/vdm_fsm.sv
// Drive mode state machine with calibration entry timestamps.
`default_nettype none

module vdm_fsm import vdm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_item       i_item,
    input  wire logic [15:0] i_hold_ms,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        S_HV_OFF   = MODE_HV_OFF,
        S_HV_ON    = MODE_HV_ON,
        S_WANT_RTD = MODE_WANT_RTD,
        S_RTD      = MODE_RTD,
        S_WANT_PED = MODE_WANT_PED,
        S_WANT_STR = MODE_WANT_STR,
        S_CAL_STR  = MODE_CAL_STR,
        S_CAL_PED  = MODE_CAL_PED
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_ped_start, n_ped_start;
    logic [31:0] r_str_start, n_str_start;
    logic [31:0] ped_elapsed;
    logic [31:0] str_elapsed;
    logic        ped_held;
    logic        str_held;
    logic        moved;

    // Wrapping elapsed time since the waiting mode was entered.
    assign ped_elapsed = i_item.now_ms - r_ped_start;
    assign str_elapsed = i_item.now_ms - r_str_start;
    assign ped_held    = ped_elapsed > {16'b0, i_hold_ms};
    assign str_held    = str_elapsed > {16'b0, i_hold_ms};

    always_comb begin
        n_state     = r_state;
        n_ped_start = r_ped_start;
        n_str_start = r_str_start;
        case (r_state)
            S_HV_OFF: begin
                if (i_item.hv_over_threshold) begin
                    n_state = S_HV_ON;
                end else if (i_item.calib_steering_btn) begin
                    n_state = S_WANT_STR;
                    // A pedal request in the same tick is entered and left at once.
                    if (i_item.calib_pedals_btn) begin
                        n_ped_start = '0;
                    end
                end else if (i_item.calib_pedals_btn) begin
                    n_state = S_WANT_PED;
                end
            end
            S_HV_ON: begin
                if (!i_item.hv_over_threshold) begin
                    n_state = S_HV_OFF;
                end else if (i_item.start_btn && i_item.brake_pressed) begin
                    n_state = S_WANT_RTD;
                end
            end
            S_WANT_RTD: begin
                if (!i_item.hv_over_threshold) begin
                    n_state = S_HV_OFF;
                end else if (i_item.drivetrain_error) begin
                    n_state = S_HV_ON;
                end else if (i_item.drivetrain_ready) begin
                    n_state = S_RTD;
                end
            end
            S_RTD: begin
                if (!i_item.hv_over_threshold) begin
                    n_state = S_HV_OFF;
                end else if (i_item.drivetrain_error || i_item.pedals_timed_out ||
                             i_item.steering_timed_out) begin
                    n_state = S_HV_ON;
                end
            end
            S_WANT_PED: begin
                if (!i_item.calib_pedals_btn) begin
                    n_state = S_HV_OFF;
                end else if (ped_held) begin
                    n_state = S_CAL_PED;
                end
            end
            S_WANT_STR: begin
                if (!i_item.calib_steering_btn) begin
                    n_state = S_HV_OFF;
                end else if (str_held) begin
                    n_state = S_CAL_STR;
                end
            end
            S_CAL_STR: begin
                if (!i_item.calib_steering_btn) begin
                    n_state = S_HV_OFF;
                end
            end
            S_CAL_PED: begin
                if (!i_item.calib_pedals_btn) begin
                    n_state = S_HV_OFF;
                end
            end
            default: begin
                n_state = S_HV_OFF;
            end
        endcase

        // Leaving a calibration mode clears its timestamp; entering a wait stamps it.
        if (n_state != r_state) begin
            if (r_state == S_WANT_PED || r_state == S_CAL_PED) begin
                n_ped_start = '0;
            end
            if (r_state == S_WANT_STR || r_state == S_CAL_STR) begin
                n_str_start = '0;
            end
            if (n_state == S_WANT_PED) begin
                n_ped_start = i_item.now_ms;
            end
            if (n_state == S_WANT_STR) begin
                n_str_start = i_item.now_ms;
            end
        end
    end

    assign moved = (n_state != r_state);

    always_comb begin
        o_result.mode                      = n_state;
        o_result.drive_enable              = (r_state == S_WANT_RTD) || (r_state == S_RTD);
        o_result.drive_torque              = (r_state == S_RTD);
        o_result.reset_inverter_pulse      = ((r_state == S_HV_OFF) || (r_state == S_HV_ON)) &&
                                             i_item.inverter_reset_btn &&
                                             i_item.drivetrain_error;
        o_result.buzzer_pulse              = moved && (n_state == S_RTD);
        o_result.reset_pedal_timeout_pulse = moved && (n_state == S_RTD);
        o_result.reset_steer_timeout_pulse = moved && (n_state == S_RTD);
        o_result.recal_pedals_pulse        = (r_state == S_CAL_PED) && i_item.calib_pedals_btn;
        o_result.recal_steering_pulse      = (r_state == S_CAL_STR) &&
                                             i_item.calib_steering_btn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HV_OFF;
            r_ped_start <= '0;
            r_str_start <= '0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_ped_start <= n_ped_start;
            r_str_start <= n_str_start;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vehicle_drive_mode_fsm_core.sv
// Top level of the vehicle drive mode state machine.
//
//  Channel   Direction  Handshake        Payload
//  i_item    in         valid / ready    one control tick (time and condition bits)
//  o_result  out        valid / ready    mode, drivetrain flags and one-tick pulses
//  APB       in         psel / penable   hold_ms at byte address 0
//
// A tick is captured in the input register and resolved against the mode and
// timestamps on the way into the result register, from which its result is
// offered; while results are taken, one tick per cycle is sustained.
// Mode and timestamps advance only when the tick moves into the result register.
// A stalled result holds the result register; an empty input register still
// takes one more tick, after which ready drops until the result is taken.
// Reset (synchronous, active low) sets mode 0, clears both timestamps and loads
// a hold time of 3000 ms.
`default_nettype none

module vehicle_drive_mode_fsm_core import vdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    vdm_in_if.sink                 i_item,
    vdm_out_if.source              o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic        r_in_valid, n_in_valid;
    t_item       r_in_item;
    logic        r_out_valid, n_out_valid;
    t_result     r_out_result;
    t_result     step_result;
    logic [15:0] hold_ms;
    logic        advance;
    logic        take_in;

    vdm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_hold_ms (hold_ms)
    );

    // The state machine commits a tick only when the result register can take it.
    vdm_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_item    (r_in_item),
        .i_hold_ms (hold_ms),
        .o_result  (step_result)
    );

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign take_in        = i_item.valid && i_item.ready;

    always_comb begin
        n_in_valid  = take_in || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_item <= i_item.data;
        end
        if (advance) begin
            r_out_result <= step_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_result;

endmodule

`default_nettype wire

FILE: rtl/vdm_checker.sv
// Port-level checker for the drive mode core, bound to the top level.
`default_nettype none

module vdm_checker import vdm_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire t_result out_data
);

    // A result transaction stays valid while the consumer stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result transaction dropped while stalled");

    // Reset empties the result register by the next edge.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // Torque is only commanded from ready, which also commands enable.
    a_torque_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_data.drive_torque) |-> out_data.drive_enable)
        else $error("drive torque without drive enable");

    // Ready-to-drive entry pulses fire together and only into ready mode.
    a_rtd_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_data.buzzer_pulse) |->
        (out_data.mode == MODE_RTD && out_data.reset_pedal_timeout_pulse &&
         out_data.reset_steer_timeout_pulse && !out_data.drive_torque))
        else $error("bad ready-to-drive entry pulses");

    // Recalibration requests come only while staying in the matching mode.
    a_recal_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |->
        ((!out_data.recal_pedals_pulse || out_data.mode == MODE_CAL_PED) &&
         (!out_data.recal_steering_pulse || out_data.mode == MODE_CAL_STR)))
        else $error("recalibration pulse outside calibration mode");

endmodule

bind vehicle_drive_mode_fsm_core vdm_checker u_vdm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_result.valid),
    .out_ready (o_result.ready),
    .out_data  (o_result.data)
);

`default_nettype wire

FILE: verif/vdm_mode_checker.sv
// Passive checker that predicts and compares every drive mode result.
`default_nettype none

module vdm_mode_checker import vdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    vdm_in_if                      in_ch,
    vdm_out_if                     out_ch,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    input  wire logic [APB_DW-1:0] i_prdata,
    input  wire logic              i_pready,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    // Shadow of the block's state and its hold time register.
    logic [2:0]  mode_q;
    logic [31:0] ped_since;
    logic [31:0] str_since;
    logic [15:0] hold_q;
    logic        rtd_entered;

    t_result expected_q[$];
    int      mismatches;
    int      compared;

    // Moves the shadow mode; leaving a calibration mode clears its timestamp.
    task automatic enter_mode(input logic [2:0] nxt, input logic [31:0] now);
        if (mode_q == MODE_WANT_PED || mode_q == MODE_CAL_PED) begin
            ped_since = '0;
        end
        if (mode_q == MODE_WANT_STR || mode_q == MODE_CAL_STR) begin
            str_since = '0;
        end
        mode_q = nxt;
        if (nxt == MODE_RTD) begin
            rtd_entered = 1'b1;
        end else if (nxt == MODE_WANT_PED) begin
            ped_since = now;
        end else if (nxt == MODE_WANT_STR) begin
            str_since = now;
        end
    endtask

    task automatic resolve_tick(input t_item t, output t_result r);
        logic [2:0]  start_mode;
        logic [31:0] elapsed;
        logic        inv_pulse;
        logic        recal_ped;
        logic        recal_str;
        start_mode  = mode_q;
        inv_pulse   = 1'b0;
        recal_ped   = 1'b0;
        recal_str   = 1'b0;
        rtd_entered = 1'b0;
        case (start_mode)
            MODE_HV_OFF: begin
                inv_pulse = t.inverter_reset_btn & t.drivetrain_error;
                if (t.hv_over_threshold) begin
                    enter_mode(MODE_HV_ON, t.now_ms);
                end else begin
                    // Steering is checked last, so it wins when both are pressed.
                    if (t.calib_pedals_btn) enter_mode(MODE_WANT_PED, t.now_ms);
                    if (t.calib_steering_btn) enter_mode(MODE_WANT_STR, t.now_ms);
                end
            end
            MODE_HV_ON: begin
                inv_pulse = t.inverter_reset_btn & t.drivetrain_error;
                if (!t.hv_over_threshold) begin
                    enter_mode(MODE_HV_OFF, t.now_ms);
                end else if (t.start_btn && t.brake_pressed) begin
                    enter_mode(MODE_WANT_RTD, t.now_ms);
                end
            end
            MODE_WANT_RTD: begin
                if (!t.hv_over_threshold) begin
                    enter_mode(MODE_HV_OFF, t.now_ms);
                end else if (t.drivetrain_error) begin
                    enter_mode(MODE_HV_ON, t.now_ms);
                end else if (t.drivetrain_ready) begin
                    enter_mode(MODE_RTD, t.now_ms);
                end
            end
            MODE_RTD: begin
                if (!t.hv_over_threshold) begin
                    enter_mode(MODE_HV_OFF, t.now_ms);
                end else if (t.drivetrain_error || t.pedals_timed_out
                             || t.steering_timed_out) begin
                    enter_mode(MODE_HV_ON, t.now_ms);
                end
            end
            MODE_WANT_PED: begin
                elapsed = t.now_ms - ped_since;
                if (!t.calib_pedals_btn) begin
                    enter_mode(MODE_HV_OFF, t.now_ms);
                end else if (elapsed > {16'd0, hold_q}) begin
                    enter_mode(MODE_CAL_PED, t.now_ms);
                end
            end
            MODE_WANT_STR: begin
                elapsed = t.now_ms - str_since;
                if (!t.calib_steering_btn) begin
                    enter_mode(MODE_HV_OFF, t.now_ms);
                end else if (elapsed > {16'd0, hold_q}) begin
                    enter_mode(MODE_CAL_STR, t.now_ms);
                end
            end
            MODE_CAL_STR: begin
                if (!t.calib_steering_btn) enter_mode(MODE_HV_OFF, t.now_ms);
                else recal_str = 1'b1;
            end
            default: begin
                if (!t.calib_pedals_btn) enter_mode(MODE_HV_OFF, t.now_ms);
                else recal_ped = 1'b1;
            end
        endcase
        r.mode                      = mode_q;
        r.drive_enable              = (start_mode == MODE_WANT_RTD) || (start_mode == MODE_RTD);
        r.drive_torque              = (start_mode == MODE_RTD);
        r.reset_inverter_pulse      = inv_pulse;
        r.buzzer_pulse              = rtd_entered;
        r.reset_pedal_timeout_pulse = rtd_entered;
        r.reset_steer_timeout_pulse = rtd_entered;
        r.recal_pedals_pulse        = recal_ped;
        r.recal_steering_pulse      = recal_str;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mode_q      = MODE_HV_OFF;
            ped_since   = '0;
            str_since   = '0;
            hold_q      = HOLD_MS_RESET;
            rtd_entered = 1'b0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_HOLD_MS) begin
                if (i_pwrite) begin
                    hold_q = i_pwdata[15:0];
                end else if (i_prdata !== APB_DW'(hold_q)) begin
                    if (mismatches < 10) begin
                        $display("hold_ms read back: expected %0d, got %0d", hold_q, i_prdata);
                    end
                    mismatches++;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                resolve_tick(in_ch.data, want);
                expected_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result with no tick waiting: mode %0d", got.mode);
                    end
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    compared++;
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("result %0d mismatch (mode en tq inv buz pto sto rp rs)",
                                     compared);
                            $display("  expected %0d %b %b %b %b %b %b %b %b", want.mode,
                                     want.drive_enable, want.drive_torque,
                                     want.reset_inverter_pulse, want.buzzer_pulse,
                                     want.reset_pedal_timeout_pulse,
                                     want.reset_steer_timeout_pulse,
                                     want.recal_pedals_pulse, want.recal_steering_pulse);
                            $display("  actual   %0d %b %b %b %b %b %b %b %b", got.mode,
                                     got.drive_enable, got.drive_torque,
                                     got.reset_inverter_pulse, got.buzzer_pulse,
                                     got.reset_pedal_timeout_pulse,
                                     got.reset_steer_timeout_pulse,
                                     got.recal_pedals_pulse, got.recal_steering_pulse);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_q.size();
        o_checked    <= compared;
    end

endmodule

`default_nettype wire

FILE: verif/tb_vehicle_drive_mode_fsm_core.sv
// Testbench top for the vehicle drive mode state machine: stimulus and verdict.
`default_nettype none

module tb_vehicle_drive_mode_fsm_core;
    import vdm_pkg::*;

    // Condition bits of a tick, in the order of the input structure after now_ms.
    localparam logic [9:0] F_HV    = 10'h200;
    localparam logic [9:0] F_INV   = 10'h100;
    localparam logic [9:0] F_ERR   = 10'h080;
    localparam logic [9:0] F_CPED  = 10'h040;
    localparam logic [9:0] F_CSTR  = 10'h020;
    localparam logic [9:0] F_START = 10'h010;
    localparam logic [9:0] F_BRAKE = 10'h008;
    localparam logic [9:0] F_RDY   = 10'h004;
    localparam logic [9:0] F_PTO   = 10'h002;
    localparam logic [9:0] F_STO   = 10'h001;

    localparam logic [APB_AW-1:0] HOLD_ADDR = {REG_HOLD_MS, 2'b00};

    // The run is split into phases, one per hold time setting.
    localparam int N_PHASES   = 7;
    localparam int CALM_AFTER = 1180;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    vdm_in_if  tick_ch ();
    vdm_out_if result_ch ();

    int          fail_count;
    int          pending;
    int          checked;
    int          ticks_sent = 0;
    logic        calm = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [15:0] hold_now = HOLD_MS_RESET;

    vehicle_drive_mode_fsm_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (tick_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The checker sees every transaction on both channels and on the APB port.
    vdm_mode_checker mode_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (tick_ch),
        .out_ch       (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_item mk_tick(input logic [31:0] now, input logic [9:0] flags);
        return t_item'({now, flags});
    endfunction

    function automatic logic [9:0] rand_flags();
        return 10'($urandom);
    endfunction

    // Ordinary time progress: small steps with an occasional jump anywhere,
    // which also makes every bit of now_ms toggle and brings wraparounds.
    function automatic logic [31:0] next_ms();
        clock_ms = clock_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 31) == 0) begin
            clock_ms = $urandom;
        end
        return clock_ms;
    endfunction

    // Drives one tick and returns at the edge where it is accepted. Gaps are
    // inserted in random bursts until the calm final stretch of the run.
    task automatic send_tick(input t_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= it;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
        if (ticks_sent >= CALM_AFTER) begin
            calm <= 1'b1;
        end
    endtask

    // One APB transaction: the setup phase, then the access phase held until pready.
    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= HOLD_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stops the tick stream and waits until every expected result is out.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // A tick that always lands in HV off: no HV and no calibrate button
    // sends every mode back to 0 and keeps mode 0 where it is.
    task automatic go_home();
        send_tick(mk_tick(next_ms(), rand_flags() & ~(F_HV | F_CPED | F_CSTR)));
    endtask

    // A well-formed drive cycle: HV on, start with brake, drivetrain ready,
    // some ticks in ready to drive, then one of the ways out or a random tick.
    task automatic drive_cycle();
        logic [9:0] f;
        go_home();
        send_tick(mk_tick(next_ms(), rand_flags() | F_HV));
        repeat ($urandom_range(0, 3)) begin
            f = rand_flags() | F_HV;
            if ($urandom_range(0, 3) != 0) f = f & ~F_START;
            send_tick(mk_tick(next_ms(), f));
        end
        send_tick(mk_tick(next_ms(), rand_flags() | F_HV | F_START | F_BRAKE));
        repeat ($urandom_range(0, 2)) begin
            f = (rand_flags() | F_HV) & ~F_RDY;
            if ($urandom_range(0, 7) != 0) f = f & ~F_ERR;
            send_tick(mk_tick(next_ms(), f));
        end
        send_tick(mk_tick(next_ms(), (rand_flags() | F_HV | F_RDY) & ~F_ERR));
        repeat ($urandom_range(1, 6)) begin
            send_tick(mk_tick(next_ms(), (rand_flags() | F_HV) & ~(F_ERR | F_PTO | F_STO)));
        end
        case ($urandom_range(0, 4))
            0: f = rand_flags() & ~F_HV;
            1: f = rand_flags() | F_HV | F_ERR;
            2: f = rand_flags() | F_HV | F_PTO;
            3: f = rand_flags() | F_HV | F_STO;
            default: f = rand_flags();
        endcase
        send_tick(mk_tick(next_ms(), f));
    endtask

    // A calibration attempt: press one or both buttons in HV off, hold the
    // winning one while time runs, sometimes right at the hold boundary,
    // and release it at the end (or early, now and then).
    task automatic calib_cycle();
        logic [9:0]  f;
        logic [9:0]  held;
        logic [31:0] t0;
        int          pick;
        go_home();
        pick = $urandom_range(1, 3);
        f = rand_flags() & ~(F_HV | F_CPED | F_CSTR);
        if (pick[0]) f = f | F_CPED;
        if (pick[1]) f = f | F_CSTR;
        held = pick[1] ? F_CSTR : F_CPED;
        t0 = next_ms();
        send_tick(mk_tick(t0, f));
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0: clock_ms = t0 + hold_now;
                1: clock_ms = t0 + hold_now + 1;
                default: clock_ms = clock_ms + $urandom_range(0, hold_now / 2 + 1);
            endcase
            f = rand_flags() | held;
            if ($urandom_range(0, 15) == 0) f = f & ~held;
            send_tick(mk_tick(clock_ms, f));
        end
        send_tick(mk_tick(next_ms(), rand_flags() & ~held));
    endtask

    // The result side takes results with random stall bursts, none at the end.
    initial begin
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Main sequence: reset, directed ticks at the reset hold time, then one
    // phase of random cycles per hold time setting, each after the first written while idle.
    initial begin
        logic [15:0] hold_plan [N_PHASES];
        int          target;
        int          kind;
        int          guard;
        i_rst_n       <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_plan[0] = HOLD_MS_RESET;
        hold_plan[1] = 16'd0;
        hold_plan[2] = 16'hFFFF;
        hold_plan[3] = 16'($urandom_range(1, 40));
        hold_plan[4] = 16'd1;
        hold_plan[5] = 16'($urandom_range(200, 5000));
        hold_plan[6] = 16'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset value of the hold time is read back first.
        apb_access(1'b0, '0);

        // Directed ticks with the reset hold time of 3000 ms.
        send_tick(mk_tick(32'd0, '0));
        send_tick(mk_tick(32'd1, F_INV | F_ERR));               // inverter reset pulse
        send_tick(mk_tick(32'd100, F_CPED | F_CSTR));           // steering request wins
        send_tick(mk_tick(32'd3100, F_CSTR));                   // held exactly hold_ms
        send_tick(mk_tick(32'd3101, F_CSTR));                   // one past: calibrate
        send_tick(mk_tick(32'd3102, F_CSTR | F_CPED));          // recalibration pulse
        send_tick(mk_tick(32'd3103, F_CPED));                   // released: back to 0
        send_tick(mk_tick(32'hFFFF_FF00, F_CPED));              // pedal wait near wrap
        send_tick(mk_tick(32'hFFFF_FFFF, F_CPED | F_STO));      // still too short
        send_tick(mk_tick(32'h0000_0C00, F_CPED));              // wrapped difference
        send_tick(mk_tick(32'h0000_0C01, F_CPED | F_HV));       // pedal recalibration
        send_tick(mk_tick(32'h0000_0C02, F_CSTR));              // released: back to 0
        send_tick(mk_tick(32'h0000_0C03, F_CPED));
        send_tick(mk_tick(32'h0000_0C04, '0));                  // let go while waiting
        send_tick(mk_tick(32'h0000_0C05, F_HV | F_CPED | F_CSTR)); // HV beats buttons
        send_tick(mk_tick(32'h0000_0C06, F_HV | F_INV | F_ERR));
        send_tick(mk_tick(32'h0000_0C07, F_HV | F_START | F_BRAKE));
        send_tick(mk_tick(32'h0000_0C08, F_HV | F_ERR | F_RDY));   // error wins over ready
        send_tick(mk_tick(32'h0000_0C09, F_HV | F_START | F_BRAKE));
        send_tick(mk_tick(32'h0000_0C0A, F_HV | F_RDY));           // enter ready to drive
        send_tick(mk_tick(32'h0000_0C0B, F_HV | F_PTO));
        send_tick(mk_tick(32'h0000_0C0C, F_HV | F_START | F_BRAKE));
        send_tick(mk_tick(32'h0000_0C0D, F_RDY));                  // HV lost while waiting
        send_tick(mk_tick(32'hFFFF_FFFF, 10'h3FF));                // all bits set
        send_tick(mk_tick(32'h0000_0000, '0));                     // HV lost in HV on

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                drain();
                apb_access(1'b1, APB_DW'(hold_plan[p]));
                apb_access(1'b0, '0);
            end
            hold_now = hold_plan[p];
            target = 20 + (p + 1) * 190;
            while (ticks_sent < target) begin
                kind = $urandom_range(0, 19);
                if (kind < 9) begin
                    drive_cycle();
                end else if (kind < 17) begin
                    calib_cycle();
                end else begin
                    repeat ($urandom_range(1, 4)) send_tick(mk_tick(next_ms(), rand_flags()));
                end
            end
        end

        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);

        $display("Sent %0d control ticks under %0d hold time settings (0 and 65535 among them),",
                 ticks_sent, N_PHASES);
        $display("with drive and calibration cycles; %0d results were compared.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[vehicle_drive_mode_fsm_core] OK");
        end else begin
            $display("[vehicle_drive_mode_fsm_core] ERROR");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #6000000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("[vehicle_drive_mode_fsm_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/vdm_pkg.sv
rtl/vdm_if.sv
rtl/vdm_cfg.sv
rtl/vdm_fsm.sv
rtl/vehicle_drive_mode_fsm_core.sv
rtl/vdm_checker.sv
verif/vdm_mode_checker.sv
verif/tb_vehicle_drive_mode_fsm_core.sv
